/* design/srwlt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwlt_pkg: shared types and constants of the striped reader/writer lock table
// Transaction structs, operation and status codes, table geometry and the
// command group that the controller drives into the datapath.
// ----------------------------------------------------------------------------
package srwlt_pkg;

  // Table geometry
  localparam int SLOT_BITS   = 10;
  localparam int READER_BITS = 31;
  localparam int TABLE_DEPTH = 1 << SLOT_BITS;
  localparam int WORD_BITS   = READER_BITS + 1;

  // Operation codes
  localparam logic [1:0] OP_WR_ACQ = 2'd0;
  localparam logic [1:0] OP_WR_REL = 2'd1;
  localparam logic [1:0] OP_RD_ACQ = 2'd2;
  localparam logic [1:0] OP_RD_REL = 2'd3;

  // Status codes
  localparam logic [1:0] ST_GRANTED   = 2'd0;
  localparam logic [1:0] ST_BLOCKED   = 2'd1;
  localparam logic [1:0] ST_WAITING   = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  // Request transaction
  typedef struct packed {
    logic [1:0] op;
    logic [9:0] slot;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [1:0]  status;
    logic        wake_writer;
    logic        wake_all;
    logic        wake_one;
    logic [30:0] readers_now;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                 clear;
    logic [SLOT_BITS-1:0] clear_addr;
    logic                 capture;
    logic                 commit;
  } cmd_t;

endpackage

/* design/striped_reader_writer_lock_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// striped_reader_writer_lock_table_top: striped reader/writer lock table
// Table of lock slots, each a writer-entered flag and a reader count, that
// answers acquire and release requests with a status and wake signals.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  srwlt_pkg::req_t (op, slot)
//   rsp      out        rsp_valid/rsp_stall  srwlt_pkg::rsp_t (status, wakes,
//                                            readers_now)
//
// A request first reads its slot from the single-port slot memory into a
// register, then updates the slot and loads the response register.
// After reset all 1024 slots are swept clear, one slot per cycle;
// req_stall stays high meanwhile.
// A waiting response does not block the next request from being accepted;
// the update stalls only while the response register is full and stalled.
// ----------------------------------------------------------------------------
module striped_reader_writer_lock_table_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  srwlt_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output srwlt_pkg::rsp_t  rsp
);

  srwlt_pkg::cmd_t cmd;

  // Sequencer
  srwlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // Slot memory and update
  srwlt_dp u_dp (
    .clk (clk),
    .req (req),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule

/* design/srwlt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwlt_ctrl: sequencer of the lock table
// Sweeps the table clear after reset, accepts one request at a time, and
// commits it once the response register is free.
// ----------------------------------------------------------------------------
module srwlt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output srwlt_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [srwlt_pkg::SLOT_BITS-1:0] clr_cnt;
  logic                            can_commit;

  // Response register is free when empty or being taken this cycle
  assign can_commit = !rsp_valid || !rsp_stall;
  assign req_stall  = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.clear_addr = clr_cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (&clr_cnt) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Hold state, sweep counter and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/srwlt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srwlt_dp: slot memory and update logic of the lock table
// Holds the writer flag and reader count of each slot, reads the named slot,
// applies the operation and writes the slot back along with the response.
// ----------------------------------------------------------------------------
module srwlt_dp (
  input  logic             clk,
  input  srwlt_pkg::req_t  req,
  input  srwlt_pkg::cmd_t  cmd,
  output srwlt_pkg::rsp_t  rsp
);

  localparam int RB = srwlt_pkg::READER_BITS;
  localparam int SB = srwlt_pkg::SLOT_BITS;

  logic [srwlt_pkg::WORD_BITS-1:0] mem [srwlt_pkg::TABLE_DEPTH];
  logic [srwlt_pkg::WORD_BITS-1:0] rd_q;
  logic [1:0]                      op_q;
  logic [SB-1:0]                   slot_q;

  logic          flag;
  logic [RB-1:0] cnt;
  logic          cnt_zero;
  logic          cnt_full;
  logic [RB-1:0] cnt_dec;
  logic          flag_next;
  logic [RB-1:0] cnt_next;
  srwlt_pkg::rsp_t rsp_next;

  assign flag     = rd_q[RB];
  assign cnt      = rd_q[RB-1:0];
  assign cnt_zero = (cnt == '0);
  assign cnt_full = &cnt;
  assign cnt_dec  = cnt - 1'b1;

  // Apply the operation to the slot that was read
  always_comb begin
    flag_next = flag;
    cnt_next  = cnt;
    rsp_next  = '0;
    rsp_next.status = srwlt_pkg::ST_GRANTED;
    case (op_q)
      srwlt_pkg::OP_WR_ACQ: begin
        if (flag) begin
          rsp_next.status = srwlt_pkg::ST_BLOCKED;
        end else begin
          flag_next = 1'b1;
          rsp_next.status = cnt_zero ? srwlt_pkg::ST_GRANTED : srwlt_pkg::ST_WAITING;
        end
      end
      srwlt_pkg::OP_WR_REL: begin
        flag_next = 1'b0;
        cnt_next  = '0;
        rsp_next.wake_all = 1'b1;
      end
      srwlt_pkg::OP_RD_ACQ: begin
        if (flag || cnt_full) begin
          rsp_next.status = srwlt_pkg::ST_BLOCKED;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        if (cnt_zero) begin
          rsp_next.status = srwlt_pkg::ST_UNDERFLOW;
        end else begin
          cnt_next = cnt_dec;
          // wake the writer when the last reader leaves, or one reader
          // when a place frees up from a full count
          rsp_next.wake_writer = flag && (cnt_dec == '0);
          rsp_next.wake_one    = !flag && cnt_full;
        end
      end
    endcase
    rsp_next.readers_now = 31'(cnt_next);
  end

  // Slot memory: clear sweep, write-back, registered read
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[cmd.clear_addr] <= '0;
    end else if (cmd.commit) begin
      mem[slot_q] <= {flag_next, cnt_next};
    end
    if (cmd.capture) begin
      rd_q   <= mem[req.slot[SB-1:0]];
      op_q   <= req.op;
      slot_q <= req.slot[SB-1:0];
    end
  end

  // Load the response register
  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= rsp_next;
  end

endmodule
